// ----- hw/rtl/chunk_frame_reassembler_core_macros.svh -----
// Assertion macros shared by the chunk frame reassembler RTL.
`ifndef CHUNK_FRAME_REASSEMBLER_CORE_MACROS_SVH
`define CHUNK_FRAME_REASSEMBLER_CORE_MACROS_SVH

`ifndef SYNTH
`define CFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/cfr_pkg.sv -----
// Types, codes and constants of the chunk frame reassembler.
package cfr_pkg;

  localparam int FRAME_BYTES_DEF = 512;
  localparam int RIDX_W          = 9;
  localparam int FLEN_W          = 10;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [2:0] ST_ACCEPT   = 3'd0;
  localparam logic [2:0] ST_IGNORE   = 3'd1;
  localparam logic [2:0] ST_ORDER    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        chunk_seq;
    logic [7:0]        chunk_index;
    logic [7:0]        chunk_total;
    logic [7:0]        chunk_bytes;
    logic [7:0]        payload_byte;
    logic [RIDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              frame_done;
    logic [FLEN_W-1:0] frame_length;
    logic [7:0]        read_data;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic load_rd;
  } cfr_cmd_t;

  typedef struct packed {
    logic is_read;
  } cfr_sts_t;

endpackage

// ----- hw/rtl/cfr_in_if.sv -----
// Input word channel of the chunk frame reassembler.
interface cfr_in_if;
  import cfr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cfr_out_if.sv -----
// Result word channel of the chunk frame reassembler.
interface cfr_out_if;
  import cfr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cfr_ctrl.sv -----
// Controller: handshake state machine and result-valid register.
`include "chunk_frame_reassembler_core_macros.svh"

module cfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  input  cfr_pkg::cfr_sts_t sts,
  output logic              in_ready,
  output logic              out_valid,
  output cfr_pkg::cfr_cmd_t cmd
);
  import cfr_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take        = in_valid && in_ready;
  assign cmd.take    = take;
  assign cmd.load_rd = (state_r == S_READ);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && sts.is_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((take && !sts.is_read) || (state_r == S_READ)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CFR_ASSERT_NXT(a_read_waits, clk, rst_n, take && sts.is_read, state_r == S_READ)
  `CFR_ASSERT_IMP(a_read_slot_free, clk, rst_n, state_r == S_READ, !out_valid_r)
  `CFR_ASSERT_NXT(a_read_delivers, clk, rst_n, state_r == S_READ, out_valid_r)

endmodule

// ----- hw/rtl/cfr_dpath.sv -----
// Datapath: frame state registers, frame store and result register.
`include "chunk_frame_reassembler_core_macros.svh"

module cfr_dpath #(
  parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfr_pkg::in_item_t  in_data,
  input  cfr_pkg::cfr_cmd_t  cmd,
  output cfr_pkg::cfr_sts_t  sts,
  output cfr_pkg::out_item_t out_data
);
  import cfr_pkg::*;

  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int SUM_W  = ((LEN_W > 8) ? LEN_W : 8) + 1;
  localparam int RCMP_W = ((LEN_W > RIDX_W) ? LEN_W : RIDX_W) + 1;

  logic             assembling_r, assembling_nxt;
  logic [7:0]       open_seq_r, open_seq_nxt;
  logic [7:0]       open_total_r, open_total_nxt;
  logic [7:0]       exp_idx_r, exp_idx_nxt;
  logic [LEN_W-1:0] filled_r, filled_nxt;
  logic [7:0]       left_r, left_nxt;
  logic             chunk_open_r, chunk_open_nxt;
  logic [LEN_W-1:0] done_len_r, done_len_nxt;

  logic [7:0]       mem [FRAME_BYTES];
  logic [7:0]       rd_data_r;
  logic             rd_inrange_r;
  out_item_t        out_r;

  logic             is_read;
  logic             new_frame;
  logic [LEN_W-1:0] eff_filled;
  logic [7:0]       eff_exp;
  logic [7:0]       eff_total;
  logic [SUM_W-1:0] hdr_sum;
  logic [7:0]       hdr_exp_inc;
  logic [7:0]       byte_exp_inc;
  logic [7:0]       left_dec;
  logic [LEN_W-1:0] filled_inc;
  logic [2:0]       status_c;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic             rd_inrange;

  assign is_read     = (in_data.req_type == REQ_READ);
  assign sts.is_read = is_read;

  assign new_frame    = (in_data.chunk_index == 8'd0);
  assign eff_filled   = new_frame ? '0 : filled_r;
  assign eff_exp      = new_frame ? 8'd0 : exp_idx_r;
  assign eff_total    = new_frame ? in_data.chunk_total : open_total_r;
  assign hdr_sum      = SUM_W'(eff_filled) + SUM_W'(in_data.chunk_bytes);
  assign hdr_exp_inc  = eff_exp + 8'd1;
  assign byte_exp_inc = exp_idx_r + 8'd1;
  assign left_dec     = left_r - 8'd1;
  assign filled_inc   = filled_r + LEN_W'(1);
  assign wr_addr      = filled_r[ADDR_W-1:0];
  assign rd_addr      = ADDR_W'(in_data.read_index);
  assign rd_inrange   = RCMP_W'(in_data.read_index) < RCMP_W'(FRAME_BYTES);

  always_comb begin
    assembling_nxt = assembling_r;
    open_seq_nxt   = open_seq_r;
    open_total_nxt = open_total_r;
    exp_idx_nxt    = exp_idx_r;
    filled_nxt     = filled_r;
    left_nxt       = left_r;
    chunk_open_nxt = chunk_open_r;
    done_len_nxt   = done_len_r;
    status_c       = ST_IGNORE;
    wr_en          = 1'b0;
    if (cmd.take) begin
      case (in_data.req_type)
        REQ_HEADER: begin
          if (in_data.chunk_total == 8'd0) begin
            status_c = ST_IGNORE;
          end else if (!new_frame && !assembling_r) begin
            status_c = ST_IGNORE;
          end else if (!new_frame && (chunk_open_r ||
                       (in_data.chunk_seq != open_seq_r) ||
                       (in_data.chunk_index != exp_idx_r) ||
                       (in_data.chunk_total != open_total_r))) begin
            status_c       = ST_ORDER;
            assembling_nxt = 1'b0;
            chunk_open_nxt = 1'b0;
            left_nxt       = 8'd0;
          end else begin
            if (new_frame) begin
              assembling_nxt = 1'b1;
              open_seq_nxt   = in_data.chunk_seq;
              open_total_nxt = in_data.chunk_total;
              exp_idx_nxt    = 8'd0;
              filled_nxt     = '0;
              chunk_open_nxt = 1'b0;
              left_nxt       = 8'd0;
            end
            if (hdr_sum > SUM_W'(FRAME_BYTES)) begin
              assembling_nxt = 1'b0;
              status_c       = ST_OVERFLOW;
            end else if (in_data.chunk_bytes == 8'd0) begin
              exp_idx_nxt    = hdr_exp_inc;
              chunk_open_nxt = 1'b0;
              left_nxt       = 8'd0;
              if (hdr_exp_inc >= eff_total) begin
                done_len_nxt   = eff_filled;
                assembling_nxt = 1'b0;
                status_c       = ST_DONE;
              end else begin
                status_c = ST_ACCEPT;
              end
            end else begin
              chunk_open_nxt = 1'b1;
              left_nxt       = in_data.chunk_bytes;
              status_c       = ST_ACCEPT;
            end
          end
        end
        REQ_BYTE: begin
          if (!assembling_r || !chunk_open_r || (left_r == 8'd0)) begin
            status_c = ST_IGNORE;
          end else begin
            wr_en      = (filled_r < LEN_W'(FRAME_BYTES));
            filled_nxt = filled_inc;
            left_nxt   = left_dec;
            status_c   = ST_ACCEPT;
            if (left_dec == 8'd0) begin
              chunk_open_nxt = 1'b0;
              exp_idx_nxt    = byte_exp_inc;
              if (byte_exp_inc >= open_total_r) begin
                done_len_nxt   = filled_inc;
                assembling_nxt = 1'b0;
                status_c       = ST_DONE;
              end
            end
          end
        end
        REQ_READ: begin
          status_c = ST_READ;
        end
        default: begin
          status_c = ST_IGNORE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assembling_r <= 1'b0;
      open_seq_r   <= 8'd0;
      open_total_r <= 8'd0;
      exp_idx_r    <= 8'd0;
      filled_r     <= '0;
      left_r       <= 8'd0;
      chunk_open_r <= 1'b0;
      done_len_r   <= '0;
    end else begin
      assembling_r <= assembling_nxt;
      open_seq_r   <= open_seq_nxt;
      open_total_r <= open_total_nxt;
      exp_idx_r    <= exp_idx_nxt;
      filled_r     <= filled_nxt;
      left_r       <= left_nxt;
      chunk_open_r <= chunk_open_nxt;
      done_len_r   <= done_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.payload_byte;
    end
    if (cmd.take && is_read) begin
      rd_data_r    <= mem[rd_addr];
      rd_inrange_r <= rd_inrange;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      out_r.status       <= ST_READ;
      out_r.frame_done   <= 1'b0;
      out_r.frame_length <= FLEN_W'(done_len_r);
      out_r.read_data    <= rd_inrange_r ? rd_data_r : 8'd0;
    end else if (cmd.take && !is_read) begin
      out_r.status       <= status_c;
      out_r.frame_done   <= (status_c == ST_DONE);
      out_r.frame_length <= FLEN_W'(done_len_nxt);
      out_r.read_data    <= 8'd0;
    end
  end

  assign out_data = out_r;

  `CFR_ASSERT_IMP(a_chunk_in_frame, clk, rst_n, chunk_open_r, assembling_r)
  `CFR_ASSERT_IMP(a_chunk_has_bytes, clk, rst_n, chunk_open_r, left_r != 8'd0)
  `CFR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, filled_r <= LEN_W'(FRAME_BYTES))

endmodule

// ----- hw/rtl/chunk_frame_reassembler_core.sv -----
// Top level of the chunk frame reassembler: controller plus datapath.
//
//  Channel  Dir  Handshake       Word
//  in_ch    in   valid / ready   header, payload byte or read request
//  out_ch   out  valid / ready   status, done flag, frame length, read byte
//
// Header and payload results are loaded into the output register; a new word is
// taken while the previous result waits there, as long as that register drains.
// Read results pass the frame store's registered read port; in_ch stalls meanwhile.
// Reset is synchronous and active low; it clears the frame state, not the store.
// A stalled out_ch holds its word and stops in_ch once the output register is full.
module chunk_frame_reassembler_core #(
  parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  cfr_in_if.sink  in_ch,
  cfr_out_if.source out_ch
);
  import cfr_pkg::*;

  cfr_cmd_t  cmd;
  cfr_sts_t  sts;
  out_item_t out_data;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  cfr_dpath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign out_ch.data = out_data;

endmodule

// ----- test/tb_chunk_frame_reassembler_core.sv -----
// Self-checking testbench for chunk_frame_reassembler_core: header, payload and read words.
module tb_chunk_frame_reassembler_core;
  import cfr_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int WATCHDOG = 2000;
  localparam int DRAIN = 8;
  localparam int WORD_TARGET = 1050;
  localparam int QUIET_FROM = 900;

  class frame_scoreboard;
    bit         assembling;
    bit         chunk_open;
    logic [7:0] open_seq;
    logic [7:0] open_total;
    logic [7:0] next_index;
    logic [7:0] chunk_left;
    int         fill_len;
    int         done_len;
    int         stored_hi;
    int         errors;
    int         checked;
    int         frames_done;
    logic [7:0] image [FRAME_BYTES_DEF];
    out_item_t  expected_q [$];

    function new();
      open_seq = '0;
      open_total = '0;
      next_index = '0;
      chunk_left = '0;
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s on result %0d: got %0h, expected %0h", what, checked, got, want);
      errors++;
    endfunction

    function logic [2:0] close_chunk();
      chunk_open = 1'b0;
      chunk_left = '0;
      next_index = next_index + 8'd1;
      if (next_index >= open_total) begin
        done_len = fill_len;
        assembling = 1'b0;
        frames_done++;
        return ST_DONE;
      end
      return ST_ACCEPT;
    endfunction

    function logic [2:0] take_header(in_item_t w);
      if (w.chunk_total == 8'd0) return ST_IGNORE;
      if (w.chunk_index == 8'd0) begin
        assembling = 1'b1;
        open_seq = w.chunk_seq;
        open_total = w.chunk_total;
        next_index = '0;
        fill_len = 0;
        chunk_open = 1'b0;
        chunk_left = '0;
      end else if (!assembling) begin
        return ST_IGNORE;
      end
      if (chunk_open || w.chunk_seq != open_seq || w.chunk_index != next_index ||
          w.chunk_total != open_total) begin
        assembling = 1'b0;
        chunk_open = 1'b0;
        chunk_left = '0;
        return ST_ORDER;
      end
      if (fill_len + int'(w.chunk_bytes) > FRAME_BYTES_DEF) begin
        assembling = 1'b0;
        return ST_OVERFLOW;
      end
      if (w.chunk_bytes == 8'd0) return close_chunk();
      chunk_open = 1'b1;
      chunk_left = w.chunk_bytes;
      return ST_ACCEPT;
    endfunction

    function logic [2:0] take_byte(logic [7:0] b);
      if (!assembling || !chunk_open || chunk_left == 8'd0) return ST_IGNORE;
      if (fill_len < FRAME_BYTES_DEF) begin
        image[fill_len[RIDX_W-1:0]] = b;
        if (fill_len >= stored_hi) stored_hi = fill_len + 1;
      end
      fill_len++;
      chunk_left = chunk_left - 8'd1;
      if (chunk_left == 8'd0) return close_chunk();
      return ST_ACCEPT;
    endfunction

    function void note_word(in_item_t w);
      logic [2:0] st;
      logic [7:0] rd;
      out_item_t  e;
      rd = '0;
      case (w.req_type)
        REQ_HEADER: st = take_header(w);
        REQ_BYTE:   st = take_byte(w.payload_byte);
        REQ_READ: begin
          st = ST_READ;
          if (int'(w.read_index) < FRAME_BYTES_DEF) rd = image[w.read_index];
        end
        default: st = ST_IGNORE;
      endcase
      e.status = st;
      e.frame_done = (st == ST_DONE);
      e.frame_length = done_len[FLEN_W-1:0];
      e.read_data = rd;
      expected_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", 16'(got.status), '0);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) report("status", 16'(got.status), 16'(e.status));
      if (got.frame_done !== e.frame_done)
        report("frame_done", 16'(got.frame_done), 16'(e.frame_done));
      if (got.frame_length !== e.frame_length)
        report("frame_length", 16'(got.frame_length), 16'(e.frame_length));
      if (got.read_data !== e.read_data)
        report("read_data", 16'(got.read_data), 16'(e.read_data));
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   words_sent;
  int   stall_cycles;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  frame_scoreboard sb = new();

  chunk_frame_reassembler_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic in_item_t rand_word();
    in_item_t w;
    w.req_type = 2'($urandom_range(0, 3));
    w.chunk_seq = 8'($urandom_range(0, 255));
    w.chunk_index = 8'($urandom_range(0, 255));
    w.chunk_total = 8'($urandom_range(0, 255));
    w.chunk_bytes = 8'($urandom_range(0, 255));
    w.payload_byte = 8'($urandom_range(0, 255));
    w.read_index = RIDX_W'($urandom_range(0, 511));
    return w;
  endfunction

  task automatic send_word(input in_item_t w, input bit counted);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (counted) words_sent++;
    if (words_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic send_header(input logic [7:0] seq, input logic [7:0] idx,
                             input logic [7:0] tot, input logic [7:0] nb);
    in_item_t w;
    w = rand_word();
    w.req_type = REQ_HEADER;
    w.chunk_seq = seq;
    w.chunk_index = idx;
    w.chunk_total = tot;
    w.chunk_bytes = nb;
    send_word(w, 1'b1);
  endtask

  task automatic send_payload(input logic [7:0] b);
    in_item_t w;
    w = rand_word();
    w.req_type = REQ_BYTE;
    w.payload_byte = b;
    send_word(w, 1'b1);
  endtask

  task automatic send_read(input int idx);
    in_item_t w;
    w = rand_word();
    w.req_type = REQ_READ;
    w.read_index = RIDX_W'(idx);
    send_word(w, 1'b1);
  endtask

  // Sends a header announcing nb bytes, then only n_sent of them.
  task automatic send_chunk(input logic [7:0] seq, input logic [7:0] idx,
                            input logic [7:0] tot, input int nb, input int n_sent);
    send_header(seq, idx, tot, 8'(nb));
    repeat (n_sent) send_payload(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_reads(input int n);
    repeat (n) begin
      if (sb.stored_hi > 0) send_read($urandom_range(0, sb.stored_hi - 1));
    end
  endtask

  task automatic send_random_frame();
    logic [7:0] seq;
    logic [7:0] s;
    logic [7:0] i;
    logic [7:0] t;
    int total;
    int fault;
    int bad;
    int nb;
    int np;
    seq = 8'($urandom_range(0, 255));
    total = $urandom_range(1, 4);
    fault = $urandom_range(0, 9);
    bad = $urandom_range(0, total - 1);
    for (int c = 0; c < total; c++) begin
      s = seq;
      i = 8'(c);
      t = 8'(total);
      nb = $urandom_range(0, 6);
      np = nb;
      if (c == bad) begin
        case (fault)
          0: s = seq ^ 8'($urandom_range(1, 255));
          1: i = 8'(c + $urandom_range(1, 3));
          2: t = 8'(total + 1);
          3: np = (nb > 0) ? $urandom_range(0, nb - 1) : 0;
          default: ;
        endcase
      end
      send_chunk(s, i, t, nb, np);
    end
  endtask

  task automatic send_noise();
    in_item_t w;
    w = rand_word();
    if (w.req_type == REQ_READ) begin
      if (sb.stored_hi == 0) w.req_type = REQ_UNKNOWN;
      else w.read_index = RIDX_W'($urandom_range(0, sb.stored_hi - 1));
    end
    send_word(w, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG) begin
        $display("Timeout with %0d results still outstanding.", sb.expected_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [7:0] seq;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;
    quiet = 1'b0;
    words_sent = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Words that arrive with no frame open, a zero total and an unknown request.
    send_payload(8'hFF);
    send_header(8'h12, 8'd5, 8'd6, 8'd2);
    send_header(8'h00, 8'd0, 8'd0, 8'd7);
    send_word('{req_type: REQ_UNKNOWN, default: '0}, 1'b1);
    // An empty single chunk completes a zero-length frame at once.
    send_header(8'hAA, 8'd0, 8'd1, 8'd0);
    // Clean two-chunk frame, then read it back.
    send_chunk(8'h55, 8'd0, 8'd2, 2, 0);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_chunk(8'h55, 8'd1, 8'd2, 1, 1);
    send_read(0);
    send_read(1);
    send_read(2);
    // A header inside an open chunk aborts; index zero there restarts instead.
    send_chunk(8'h01, 8'd0, 8'd2, 3, 1);
    send_header(8'h01, 8'd1, 8'd2, 8'd1);
    send_chunk(8'h02, 8'd0, 8'd1, 2, 1);
    send_chunk(8'h03, 8'd0, 8'd1, 1, 1);
    // Wrong sequence, wrong index and wrong total each abort the frame.
    send_header(8'h04, 8'd0, 8'd2, 8'd0);
    send_header(8'h05, 8'd1, 8'd2, 8'd0);
    send_header(8'h06, 8'd0, 8'd3, 8'd0);
    send_header(8'h06, 8'd2, 8'd3, 8'd0);
    send_header(8'h07, 8'd0, 8'd3, 8'd0);
    send_header(8'h07, 8'd1, 8'd4, 8'd0);
    send_payload(8'h3C);
    send_header(8'hFF, 8'd0, 8'd255, 8'd0);

    // A frame that fills the whole store, then one that overflows it.
    seq = 8'($urandom_range(0, 255));
    send_chunk(seq, 8'd0, 8'd3, 255, 255);
    send_chunk(seq, 8'd1, 8'd3, 255, 255);
    send_chunk(seq, 8'd2, 8'd3, 2, 2);
    send_read(FRAME_BYTES_DEF - 1);
    send_read(256);
    send_read(255);
    send_chunk(seq + 8'd1, 8'd0, 8'd3, 255, 255);
    send_chunk(seq + 8'd1, 8'd1, 8'd3, 3, 3);
    send_header(seq + 8'd1, 8'd2, 8'd3, 8'd255);
    send_payload(8'h81);

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          send_random_frame();
          send_random_reads($urandom_range(0, 2));
        end
        7, 8: send_random_reads($urandom_range(1, 4));
        default: repeat ($urandom_range(1, 3)) send_noise();
      endcase
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d words; %0d results checked, %0d frames reassembled.",
             words_sent, sb.checked, sb.frames_done);
    $display("Stimulus covered a full-size frame, an overflow, order faults and reads.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_in_if.sv
hw/rtl/cfr_out_if.sv
hw/rtl/cfr_ctrl.sv
hw/rtl/cfr_dpath.sv
hw/rtl/chunk_frame_reassembler_core.sv
test/tb_chunk_frame_reassembler_core.sv
